/* design/double_q_learning_update_defines.svh */
// Assertion macros for the double Q-learning update block.
// Used by the top level; no other dependencies.
`ifndef DOUBLE_Q_LEARNING_UPDATE_DEFINES_SVH
`define DOUBLE_Q_LEARNING_UPDATE_DEFINES_SVH
// implication checked every clock outside reset
`define DQL_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define DQL_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

/* design/dql_pkg.sv */
// Shared types and constants for the double Q-learning update block.
// No dependencies.
package dql_pkg;
    localparam int STATE_BITS = 11;
    localparam int VALUE_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int RATE_BITS  = 17;
    localparam int RATE_SHIFT = 16;
    localparam int DRAW_BITS  = 16;
    localparam int RANK_BITS  = 8;
    localparam int ACT_BITS   = 2;
    localparam int NUM_ACT    = 3;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISCOUNT      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXPLORE       = 2'd2;

    localparam logic [RATE_BITS-1:0] RATE_ONE      = 17'd65536;
    localparam logic [RATE_BITS-1:0] RESET_ALPHA   = 17'd6554;
    localparam logic [RATE_BITS-1:0] RESET_GAMMA   = 17'd65536;
    localparam logic [RATE_BITS-1:0] RESET_EPSILON = 17'd6554;

    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [ACT_BITS-1:0] ACT_STAND  = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_HIT    = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_DOUBLE = 2'd2;
    localparam logic [ACT_BITS-1:0] ACT_NONE   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_READ, ST_WAIT, ST_PICK, ST_MUL1, ST_MUL2,
        ST_WRITE, ST_OUT
    } t_back_state;

    // explore pick: (rank mod count)-th set bit of the legal mask
    function automatic logic [ACT_BITS-1:0] explore_pick(input logic [2:0] legal,
                                                         input logic [RANK_BITS-1:0] rank);
        logic [1:0] cnt;
        logic [1:0] k;
        logic [3:0] rsum;
        logic [ACT_BITS-1:0] res;
        cnt = 2'(legal[0]) + 2'(legal[1]) + 2'(legal[2]);
        // rank mod 3: base-4 digits each weigh 1 mod 3, then fold
        rsum = 4'(rank[1:0]) + 4'(rank[3:2]) + 4'(rank[5:4]) + 4'(rank[7:6]);
        if (rsum >= 4'd6) rsum = rsum - 4'd6;
        if (rsum >= 4'd3) rsum = rsum - 4'd3;
        if (rsum >= 4'd3) rsum = rsum - 4'd3;
        unique case (cnt)
            2'd1:    k = 2'd0;
            2'd2:    k = {1'b0, rank[0]};
            2'd3:    k = rsum[1:0];
            default: k = 2'd0;
        endcase
        res = ACT_STAND;
        if (cnt != 2'd0) begin
            if (legal[0] && k == 2'd0) res = ACT_STAND;
            else if (legal[0] && legal[1] && k == 2'd1) res = ACT_HIT;
            else if (!legal[0] && legal[1] && k == 2'd0) res = ACT_HIT;
            else res = ACT_DOUBLE;
        end
        return res;
    endfunction
endpackage

/* design/dql_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface dql_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/dql_front.sv */
// Front part: accepts items, classifies them and decides the explore pick.
// Depends on dql_pkg.
module dql_front #(
    parameter int STATE_BITS = dql_pkg::STATE_BITS,
    parameter int VALUE_BITS = dql_pkg::VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [STATE_BITS-1:0]           i_cur_state,
    input  logic [dql_pkg::ACT_BITS-1:0]    i_action,
    input  logic signed [VALUE_BITS-1:0]    i_reward,
    input  logic                            i_episode_over,
    input  logic [STATE_BITS-1:0]           i_next_state,
    input  logic [2:0]                      i_legal_mask,
    input  logic                            i_update_first,
    input  logic [dql_pkg::DRAW_BITS-1:0]   i_explore_draw,
    input  logic [dql_pkg::RANK_BITS-1:0]   i_pick_rank,
    input  logic [dql_pkg::RATE_BITS-1:0]   i_epsilon,
    // two-entry queue toward the back part
    output logic                            o_q_valid,
    input  logic                            i_q_pop,
    output logic                            o_q_op,
    output logic                            o_q_explore,
    output logic [dql_pkg::ACT_BITS-1:0]    o_q_action,
    output logic [STATE_BITS-1:0]           o_q_cur,
    output logic [STATE_BITS-1:0]           o_q_next,
    output logic signed [VALUE_BITS-1:0]    o_q_reward,
    output logic                            o_q_over,
    output logic [2:0]                      o_q_legal,
    output logic                            o_q_upd_a
);
    localparam int W = 1 + 1 + dql_pkg::ACT_BITS + 2*STATE_BITS + VALUE_BITS + 1 + 3 + 1;
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic [W-1:0] w_in;
    logic         w_push, w_explore;
    logic [dql_pkg::ACT_BITS-1:0] w_act;

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign w_explore = ({1'b0, i_explore_draw} < i_epsilon);
    // for an explored select the pick is resolved here and carried as action
    assign w_act = (i_op == dql_pkg::OP_SELECT && w_explore)
                   ? dql_pkg::explore_pick(i_legal_mask, i_pick_rank) : i_action;
    assign w_in = {i_op, w_explore, w_act, i_cur_state, i_next_state, i_reward,
                   i_episode_over, i_legal_mask, i_update_first};

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_in;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign {o_q_op, o_q_explore, o_q_action, o_q_cur, o_q_next, o_q_reward,
            o_q_over, o_q_legal, o_q_upd_a} = r_mem[r_rp];
endmodule

/* design/dql_back.sv */
// Back part: Q stores with clearing pass, argmax, two multiplies, write-back.
// Depends on dql_pkg.
module dql_back #(
    parameter int STATE_BITS = dql_pkg::STATE_BITS,
    parameter int VALUE_BITS = dql_pkg::VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    output logic                            o_q_pop,
    input  logic                            i_q_op,
    input  logic                            i_q_explore,
    input  logic [dql_pkg::ACT_BITS-1:0]    i_q_action,
    input  logic [STATE_BITS-1:0]           i_q_cur,
    input  logic [STATE_BITS-1:0]           i_q_next,
    input  logic signed [VALUE_BITS-1:0]    i_q_reward,
    input  logic                            i_q_over,
    input  logic [2:0]                      i_q_legal,
    input  logic                            i_q_upd_a,
    input  logic [dql_pkg::RATE_BITS-1:0]   i_alpha,
    input  logic [dql_pkg::RATE_BITS-1:0]   i_gamma,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [dql_pkg::ACT_BITS-1:0]    o_action,
    output logic signed [VALUE_BITS-1:0]    o_updated,
    output logic signed [VALUE_BITS-1:0]    o_averaged,
    output logic                            o_busy
);
    localparam int ROWS = 1 << STATE_BITS;
    localparam int RW   = 3 * VALUE_BITS;
    localparam int TW   = VALUE_BITS + 2;           // target width
    localparam int PW   = TW + dql_pkg::RATE_BITS + 1;
    localparam logic signed [VALUE_BITS+1:0] VMAX = (VALUE_BITS+2)'((1 << (VALUE_BITS-1)) - 1);
    localparam logic signed [VALUE_BITS+1:0] VMIN = -VMAX - 1;

    logic [RW-1:0] mem_a [ROWS];
    logic [RW-1:0] mem_b [ROWS];
    logic [RW-1:0] r_ca, r_cb, r_na, r_nb;

    dql_pkg::t_back_state r_st, n_st;
    logic [STATE_BITS:0]  r_clr;
    logic [dql_pkg::ACT_BITS-1:0] r_act;
    logic signed [TW-1:0] r_target;
    logic signed [VALUE_BITS-1:0] r_cell, r_new;
    logic signed [PW-1:0] r_prod;

    logic [STATE_BITS-1:0] w_addr_c;
    logic w_we_a, w_we_b;
    logic [RW-1:0] w_wdata;

    function automatic logic signed [VALUE_BITS-1:0] cell_of(input logic [RW-1:0] row,
                                                             input logic [1:0] a);
        logic signed [VALUE_BITS-1:0] v;
        unique case (a)
            dql_pkg::ACT_HIT:    v = row[2*VALUE_BITS-1:VALUE_BITS];
            dql_pkg::ACT_DOUBLE: v = row[3*VALUE_BITS-1:2*VALUE_BITS];
            default:             v = row[VALUE_BITS-1:0];
        endcase
        return v;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] avg2(input logic signed [VALUE_BITS-1:0] x,
                                                          input logic signed [VALUE_BITS-1:0] y);
        logic signed [VALUE_BITS:0] s;
        s = (VALUE_BITS+1)'(x) + (VALUE_BITS+1)'(y);
        return s[VALUE_BITS:1];
    endfunction

    // argmax over the legal mask; ties to lowest, none legal gives stand
    function automatic logic [1:0] argmax3(input logic signed [VALUE_BITS-1:0] v0,
                                           input logic signed [VALUE_BITS-1:0] v1,
                                           input logic signed [VALUE_BITS-1:0] v2,
                                           input logic [2:0] legal);
        logic [1:0] b;
        logic signed [VALUE_BITS-1:0] bv;
        logic any;
        b = dql_pkg::ACT_STAND; bv = v0; any = legal[0];
        if (legal[1] && (!any || v1 > bv)) begin b = dql_pkg::ACT_HIT; bv = v1; any = 1'b1; end
        if (legal[2] && (!any || v2 > bv)) b = dql_pkg::ACT_DOUBLE;
        return b;
    endfunction

    logic signed [VALUE_BITS-1:0] w_c0, w_c1, w_c2, w_boot, w_cell, w_new;
    logic [1:0] w_best, w_nb;
    logic [dql_pkg::RATE_BITS-1:0] w_alpha, w_gamma;
    logic signed [TW-1:0] w_diff;
    logic signed [PW-1:0] w_sum, w_nv;
    logic [RW-1:0] w_own_row, w_upd_row;
    logic w_rd_next;

    // memories: one synchronous read per store per cycle, one write
    assign w_addr_c = (r_st == dql_pkg::ST_CLEAR) ? r_clr[STATE_BITS-1:0] : i_q_cur;
    assign w_we_a = (r_st == dql_pkg::ST_CLEAR) || (r_st == dql_pkg::ST_WRITE && i_q_upd_a);
    assign w_we_b = (r_st == dql_pkg::ST_CLEAR) || (r_st == dql_pkg::ST_WRITE && !i_q_upd_a);
    assign w_wdata = (r_st == dql_pkg::ST_CLEAR) ? '0 : w_upd_row;

    always_ff @(posedge i_clk) begin
        if (w_we_a) mem_a[w_addr_c] <= w_wdata;
        if (w_we_b) mem_b[w_addr_c] <= w_wdata;
        // read next row in READ, current row in every other state
        if (w_rd_next) begin
            r_na <= mem_a[i_q_next];
            r_nb <= mem_b[i_q_next];
        end else begin
            r_ca <= mem_a[i_q_cur];
            r_cb <= mem_b[i_q_cur];
        end
    end

    assign w_alpha = (i_alpha > dql_pkg::RATE_ONE) ? dql_pkg::RATE_ONE : i_alpha;
    assign w_gamma = (i_gamma > dql_pkg::RATE_ONE) ? dql_pkg::RATE_ONE : i_gamma;
    assign w_c0 = avg2(cell_of(r_ca, 2'd0), cell_of(r_cb, 2'd0));
    assign w_c1 = avg2(cell_of(r_ca, 2'd1), cell_of(r_cb, 2'd1));
    assign w_c2 = avg2(cell_of(r_ca, 2'd2), cell_of(r_cb, 2'd2));
    assign w_best = argmax3(w_c0, w_c1, w_c2, i_q_legal);
    assign w_own_row = i_q_upd_a ? r_na : r_nb;
    assign w_nb = argmax3(cell_of(w_own_row, 2'd0), cell_of(w_own_row, 2'd1),
                          cell_of(w_own_row, 2'd2), i_q_legal);
    assign w_boot = cell_of(i_q_upd_a ? r_nb : r_na, w_nb);
    assign w_cell = cell_of(i_q_upd_a ? r_ca : r_cb, r_act);
    assign w_diff = r_target - TW'(r_cell);
    assign w_sum = r_prod + (PW'(r_cell) <<< dql_pkg::RATE_SHIFT);

    // saturated new value, valid in WRITE once the second product is in
    assign w_nv = w_sum >>> dql_pkg::RATE_SHIFT;
    always_comb begin
        if (w_nv > PW'(VMAX)) w_new = VMAX[VALUE_BITS-1:0];
        else if (w_nv < PW'(VMIN)) w_new = VMIN[VALUE_BITS-1:0];
        else w_new = w_nv[VALUE_BITS-1:0];
    end

    always_comb begin
        w_upd_row = i_q_upd_a ? r_ca : r_cb;
        unique case (r_act)
            dql_pkg::ACT_HIT:    w_upd_row[2*VALUE_BITS-1:VALUE_BITS] = w_new;
            dql_pkg::ACT_DOUBLE: w_upd_row[3*VALUE_BITS-1:2*VALUE_BITS] = w_new;
            default:             w_upd_row[VALUE_BITS-1:0] = w_new;
        endcase
    end

    always_comb begin
        n_st = r_st;
        o_q_pop = 1'b0;
        w_rd_next = (r_st == dql_pkg::ST_READ);
        unique case (r_st)
            dql_pkg::ST_CLEAR: if (r_clr == (STATE_BITS+1)'(ROWS-1)) n_st = dql_pkg::ST_IDLE;
            dql_pkg::ST_IDLE:  if (i_q_valid) n_st = dql_pkg::ST_READ;
            dql_pkg::ST_READ:  n_st = dql_pkg::ST_WAIT;
            dql_pkg::ST_WAIT:  n_st = dql_pkg::ST_PICK;
            dql_pkg::ST_PICK:
                if (i_q_op == dql_pkg::OP_SELECT || i_q_action == dql_pkg::ACT_NONE)
                    n_st = dql_pkg::ST_OUT;
                else n_st = dql_pkg::ST_MUL1;
            dql_pkg::ST_MUL1:  n_st = dql_pkg::ST_MUL2;
            dql_pkg::ST_MUL2:  n_st = dql_pkg::ST_WRITE;
            dql_pkg::ST_WRITE: n_st = dql_pkg::ST_OUT;
            dql_pkg::ST_OUT: if (!o_valid) begin
                n_st = dql_pkg::ST_IDLE; o_q_pop = 1'b1;
            end
            default: n_st = dql_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= dql_pkg::ST_CLEAR;
            r_clr <= '0;
            o_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == dql_pkg::ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (o_valid && i_ready) o_valid <= 1'b0;
            if (r_st == dql_pkg::ST_OUT && !o_valid) o_valid <= 1'b1;
        end
        unique case (r_st)
            dql_pkg::ST_PICK: begin
                r_act <= (i_q_op == dql_pkg::OP_SELECT)
                         ? (i_q_explore ? i_q_action : w_best) : i_q_action;
                // bootstrap product: gamma * boot
                r_prod <= PW'(signed'({1'b0, w_gamma})) * PW'(w_boot);
            end
            dql_pkg::ST_MUL1: begin
                r_cell <= w_cell;
                r_target <= TW'(i_q_reward) +
                            (i_q_over ? TW'(0) : TW'(r_prod >>> dql_pkg::RATE_SHIFT));
            end
            dql_pkg::ST_MUL2: r_prod <= PW'(signed'({1'b0, w_alpha})) * PW'(w_diff);
            dql_pkg::ST_WRITE: begin
                r_new <= w_new;
            end
            default: ;
        endcase
        if (r_st == dql_pkg::ST_OUT && !o_valid) begin
            o_action <= r_act;
            if (i_q_op == dql_pkg::OP_SELECT) begin
                o_updated <= '0;
                o_averaged <= avg2(cell_of(r_ca, r_act), cell_of(r_cb, r_act));
            end else if (r_act == dql_pkg::ACT_NONE) begin
                o_updated <= '0;
                o_averaged <= '0;
            end else begin
                o_updated <= r_new;
                o_averaged <= i_q_upd_a ? avg2(r_new, cell_of(r_cb, r_act))
                                        : avg2(cell_of(r_ca, r_act), r_new);
            end
        end
    end

    assign o_busy = (r_st == dql_pkg::ST_CLEAR);
endmodule

/* design/double_q_learning_update.sv */
// Top level of the double Q-learning update block.
// Depends on dql_pkg, dql_front, dql_back and the defines header.
//
// Double Q-learning engine with two Q stores of 3 values per state. A front
// stage takes items into a two-entry queue; the back part reads both stores,
// picks the action and, for an update, runs the two multiplies and writes
// one cell. The back part handles one item at a time: a select passes the
// idle check, the next row read, the wait for the current row, the pick and
// the output load; an update with a valid action adds the two multiply
// states and the write. One read port per store and the two dependent
// multiplies set this sequence. A result still waiting at the output holds
// the back part, and the next result is loaded only once the old one has
// left the output. After reset a clearing pass over all 2^STATE_BITS rows
// zeroes the stores before items are accepted.
`include "double_q_learning_update_defines.svh"
module double_q_learning_update #(
    parameter int STATE_BITS = dql_pkg::STATE_BITS,
    parameter int VALUE_BITS = dql_pkg::VALUE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [dql_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [dql_pkg::RATE_BITS-1:0]    i_cfg_data,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_op,
    input  logic [STATE_BITS-1:0] i_cur_state,
    input  logic [dql_pkg::ACT_BITS-1:0] i_action,
    input  logic signed [VALUE_BITS-1:0] i_reward,
    input  logic i_episode_over,
    input  logic [STATE_BITS-1:0] i_next_state,
    input  logic [2:0] i_legal_mask,
    input  logic i_update_first,
    input  logic [dql_pkg::DRAW_BITS-1:0] i_explore_draw,
    input  logic [dql_pkg::RANK_BITS-1:0] i_pick_rank,
    output logic o_valid,
    input  logic i_ready,
    output logic [dql_pkg::ACT_BITS-1:0] o_chosen_action,
    output logic signed [VALUE_BITS-1:0] o_updated_value,
    output logic signed [VALUE_BITS-1:0] o_averaged_value
);
    logic [dql_pkg::RATE_BITS-1:0] r_alpha, r_gamma, r_eps;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= dql_pkg::RESET_ALPHA;
            r_gamma <= dql_pkg::RESET_GAMMA;
            r_eps   <= dql_pkg::RESET_EPSILON;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dql_pkg::CFG_LEARNING_RATE: r_alpha <= i_cfg_data;
                dql_pkg::CFG_DISCOUNT:      r_gamma <= i_cfg_data;
                dql_pkg::CFG_EXPLORE:       r_eps   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic q_valid, q_pop, q_op, q_explore, q_over, q_upd_a, busy, f_ready;
    logic [dql_pkg::ACT_BITS-1:0] q_action;
    logic [STATE_BITS-1:0] q_cur, q_next;
    logic signed [VALUE_BITS-1:0] q_reward;
    logic [2:0] q_legal;

    assign o_ready = f_ready && !busy;

    dql_front #(.STATE_BITS(STATE_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid(i_valid && !busy), .o_ready(f_ready),
        .i_op, .i_cur_state, .i_action, .i_reward, .i_episode_over, .i_next_state,
        .i_legal_mask, .i_update_first, .i_explore_draw, .i_pick_rank,
        .i_epsilon(r_eps),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_op(q_op), .o_q_explore(q_explore),
        .o_q_action(q_action), .o_q_cur(q_cur), .o_q_next(q_next),
        .o_q_reward(q_reward), .o_q_over(q_over), .o_q_legal(q_legal),
        .o_q_upd_a(q_upd_a)
    );

    dql_back #(.STATE_BITS(STATE_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_op(q_op),
        .i_q_explore(q_explore), .i_q_action(q_action), .i_q_cur(q_cur),
        .i_q_next(q_next), .i_q_reward(q_reward), .i_q_over(q_over),
        .i_q_legal(q_legal), .i_q_upd_a(q_upd_a), .i_alpha(r_alpha),
        .i_gamma(r_gamma), .o_valid, .i_ready, .o_action(o_chosen_action),
        .o_updated(o_updated_value), .o_averaged(o_averaged_value), .o_busy(busy)
    );

    `DQL_ASSERT_IMP(a_no_accept_clear, i_clk, i_rst_n, busy, !o_ready, "accept during clear")
    `DQL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped")
    `DQL_ASSERT_IMP(a_pop_valid, i_clk, i_rst_n, q_pop, q_valid, "pop from empty queue")
endmodule

/* tb/dql_tb_pkg.sv */
// Transfer types for the double Q-learning update testbench.
// Depends on dql_pkg from the design.
package dql_tb_pkg;
    import dql_pkg::*;

    typedef struct packed {
        logic                         op;
        logic [STATE_BITS-1:0]        cur_state;
        logic [ACT_BITS-1:0]          action;
        logic signed [VALUE_BITS-1:0] reward;
        logic                         episode_over;
        logic [STATE_BITS-1:0]        next_state;
        logic [2:0]                   legal_mask;
        logic                         update_first;
        logic [DRAW_BITS-1:0]         explore_draw;
        logic [RANK_BITS-1:0]         pick_rank;
    } step_t;

    typedef struct packed {
        logic [ACT_BITS-1:0]          chosen_action;
        logic signed [VALUE_BITS-1:0] updated_value;
        logic signed [VALUE_BITS-1:0] averaged_value;
    } outcome_t;
endpackage

/* tb/dql_checker.sv */
// Checker for the double Q-learning update block: mirrors both Q tables,
// predicts each outcome and compares. Depends on dql_pkg, dql_tb_pkg, dql_if.
module dql_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [dql_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [dql_pkg::RATE_BITS-1:0]    i_cfg_data,
    dql_if step_ch,
    dql_if outcome_ch,
    output int o_errors,
    output int o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dql_pkg::*;
    import dql_tb_pkg::*;

    localparam int NROWS = 1 << STATE_BITS;
    localparam int SRC_A = 0;
    localparam int SRC_B = 1;
    localparam int SRC_AVG = 2;
    localparam longint VMAX = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;

    longint q_a [NROWS][NUM_ACT];
    longint q_b [NROWS][NUM_ACT];
    logic [RATE_BITS-1:0] alpha_r, gamma_r, eps_r;
    outcome_t expected_q[$];

    function automatic longint mean_ab(int row, int act);
        return (q_a[row][act] + q_b[row][act]) >>> 1;
    endfunction

    function automatic int best_act(int row, logic [2:0] legal, int src);
        int best;
        longint best_v, v;
        bit any;
        best = 0; best_v = 0; any = 0;
        for (int a = 0; a < NUM_ACT; a++) begin
            if (legal[a]) begin
                v = (src == SRC_A) ? q_a[row][a] : (src == SRC_B) ? q_b[row][a] : mean_ab(row, a);
                if (!any || v > best_v) begin
                    best = a; best_v = v; any = 1;
                end
            end
        end
        return best;
    endfunction

    function automatic outcome_t predict_outcome(step_t s);
        outcome_t r;
        int cur, nxt, cnt, k, act;
        longint alpha, gamma, target, old_v, nv, boot;
        cur = int'(s.cur_state); nxt = int'(s.next_state);
        act = int'(s.action);
        r = '0;
        if (s.op == OP_SELECT) begin
            act = 0;
            if (17'(s.explore_draw) < eps_r) begin
                cnt = s.legal_mask[0] + s.legal_mask[1] + s.legal_mask[2];
                if (cnt != 0) begin
                    k = int'(s.pick_rank) % cnt;
                    for (int a = NUM_ACT - 1; a >= 0; a--)
                        if (s.legal_mask[a]) begin
                            cnt--;
                            if (cnt == k) act = a;
                        end
                end
            end else begin
                act = best_act(cur, s.legal_mask, SRC_AVG);
            end
            r.chosen_action = ACT_BITS'(act);
            r.averaged_value = VALUE_BITS'(mean_ab(cur, act));
            return r;
        end
        r.chosen_action = s.action;
        if (s.action == ACT_NONE) return r;
        alpha = (alpha_r > RATE_ONE) ? longint'(RATE_ONE) : longint'(alpha_r);
        gamma = (gamma_r > RATE_ONE) ? longint'(RATE_ONE) : longint'(gamma_r);
        target = longint'(s.reward);
        if (!s.episode_over) begin
            if (s.update_first) boot = q_b[nxt][best_act(nxt, s.legal_mask, SRC_A)];
            else boot = q_a[nxt][best_act(nxt, s.legal_mask, SRC_B)];
            target += (gamma * boot) >>> 16;
        end
        old_v = s.update_first ? q_a[cur][act] : q_b[cur][act];
        nv = old_v + ((alpha * (target - old_v)) >>> 16);
        if (nv > VMAX) nv = VMAX;
        if (nv < VMIN) nv = VMIN;
        if (s.update_first) q_a[cur][act] = nv;
        else q_b[cur][act] = nv;
        r.updated_value = VALUE_BITS'(nv);
        r.averaged_value = VALUE_BITS'(mean_ab(cur, act));
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        outcome_t got, want;
        if (!i_rst_n) begin
            for (int r = 0; r < NROWS; r++)
                for (int a = 0; a < NUM_ACT; a++) begin
                    q_a[r][a] = 0; q_b[r][a] = 0;
                end
            alpha_r = RESET_ALPHA; gamma_r = RESET_GAMMA; eps_r = RESET_EPSILON;
            expected_q.delete();
        end else begin
            if (outcome_ch.valid && outcome_ch.ready) begin
                got = outcome_ch.data;
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected outcome transfer", $realtime);
                    o_errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.chosen_action !== want.chosen_action)
                        report("chosen_action", got.chosen_action, want.chosen_action);
                    if (got.updated_value !== want.updated_value)
                        report("updated_value", got.updated_value, want.updated_value);
                    if (got.averaged_value !== want.averaged_value)
                        report("averaged_value", got.averaged_value, want.averaged_value);
                end
            end
            if (step_ch.valid && step_ch.ready)
                expected_q.push_back(predict_outcome(step_ch.data));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LEARNING_RATE: alpha_r = i_cfg_data;
                    CFG_DISCOUNT:      gamma_r = i_cfg_data;
                    CFG_EXPLORE:       eps_r = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

/* tb/tb.sv */
// Top of the double Q-learning update testbench: clock, reset, stimulus
// and verdict. Depends on dql_pkg, dql_tb_pkg, dql_if and dql_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dql_pkg::*;
    import dql_tb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_PER_PHASE = 180;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [RATE_BITS-1:0] i_cfg_data = '0;
    int errors, pending, cycles, sent, phases;
    bit calm_sink;

    dql_if #(.T(step_t)) step_ch ();
    dql_if #(.T(outcome_t)) outcome_ch ();
    logic [ACT_BITS-1:0] out_act;
    logic signed [VALUE_BITS-1:0] out_upd, out_avg;

    always #6 i_clk = ~i_clk;

    double_q_learning_update DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(step_ch.valid), .o_ready(step_ch.ready),
        .i_op(step_ch.data.op), .i_cur_state(step_ch.data.cur_state),
        .i_action(step_ch.data.action), .i_reward(step_ch.data.reward),
        .i_episode_over(step_ch.data.episode_over),
        .i_next_state(step_ch.data.next_state), .i_legal_mask(step_ch.data.legal_mask),
        .i_update_first(step_ch.data.update_first),
        .i_explore_draw(step_ch.data.explore_draw), .i_pick_rank(step_ch.data.pick_rank),
        .o_valid(outcome_ch.valid), .i_ready(outcome_ch.ready),
        .o_chosen_action(out_act), .o_updated_value(out_upd), .o_averaged_value(out_avg)
    );
    assign outcome_ch.data = '{out_act, out_upd, out_avg};

    dql_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .step_ch(step_ch), .outcome_ch(outcome_ch), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        step_ch.valid = 1'b0;
        step_ch.data = '0;
        outcome_ch.ready = 1'b0;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (calm_sink) outcome_ch.ready <= 1'b1;
        else outcome_ch.ready <= (gap_len() == 0);
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end
    initial cycles = 0;

    task automatic send_step(step_t s, int gap);
        step_ch.valid <= 1'b1;
        step_ch.data <= s;
        do @(posedge i_clk); while (!step_ch.ready);
        sent++;
        if (gap > 0) begin
            step_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for a clock edge first so the count already holds the last accepted item
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_rates(logic [RATE_BITS-1:0] a, logic [RATE_BITS-1:0] g,
                             logic [RATE_BITS-1:0] e);
        i_cfg_we <= 1'b1; i_cfg_index <= CFG_LEARNING_RATE; i_cfg_data <= a;
        @(posedge i_clk);
        i_cfg_index <= CFG_DISCOUNT; i_cfg_data <= g;
        @(posedge i_clk);
        i_cfg_index <= CFG_EXPLORE; i_cfg_data <= e;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic step_t rand_step();
        step_t s;
        s.op = 1'($urandom_range(0, 1));
        // a small pool of rows makes cells build up real values
        s.cur_state = ($urandom_range(0, 9) < 8) ? STATE_BITS'($urandom_range(0, 7)) :
                      STATE_BITS'($urandom);
        s.next_state = ($urandom_range(0, 9) < 8) ? STATE_BITS'($urandom_range(0, 7)) :
                       STATE_BITS'($urandom);
        s.action = ($urandom_range(0, 19) == 0) ? ACT_NONE : ACT_BITS'($urandom_range(0, 2));
        s.reward = ($urandom_range(0, 9) < 8) ?
                   VALUE_BITS'($signed($urandom_range(0, 1 << 19)) - (1 << 18)) :
                   VALUE_BITS'($urandom);
        s.episode_over = ($urandom_range(0, 3) == 0);
        s.legal_mask = 3'($urandom_range(0, 7));
        s.update_first = 1'($urandom_range(0, 1));
        s.explore_draw = DRAW_BITS'($urandom);
        s.pick_rank = RANK_BITS'($urandom);
        return s;
    endfunction

    task automatic directed_steps();
        step_t s;
        // select on cleared tables, every legal mask, explore and greedy
        for (int m = 0; m < 8; m++) begin
            s = '0; s.op = OP_SELECT; s.legal_mask = 3'(m);
            s.explore_draw = (m % 2) ? '0 : '1;
            s.pick_rank = (m < 4) ? '1 : 8'd5;
            s.cur_state = (m % 2) ? '1 : '0;
            send_step(s, 0);
        end
        // updates: extreme rewards, terminal and bootstrapped, both tables
        for (int k = 0; k < 8; k++) begin
            s = '0; s.op = OP_UPDATE;
            s.action = ACT_BITS'(k % 3);
            s.reward = (k % 2) ? {1'b1, {(VALUE_BITS-1){1'b0}}} : {1'b0, {(VALUE_BITS-1){1'b1}}};
            s.episode_over = k[1];
            s.update_first = k[2];
            s.legal_mask = 3'(k);
            s.cur_state = STATE_BITS'(k % 2);
            s.next_state = STATE_BITS'((k + 1) % 2);
            send_step(s, k % 2);
        end
        // invalid action: nothing written
        s = '0; s.op = OP_UPDATE; s.action = ACT_NONE; s.reward = 24'sd65536;
        send_step(s, 0);
        // greedy ties and no-legal case after values exist
        for (int m = 0; m < 8; m++) begin
            s = '0; s.op = OP_SELECT; s.legal_mask = 3'(m); s.explore_draw = '1;
            s.cur_state = STATE_BITS'(m % 2);
            send_step(s, 1);
        end
    endtask

    initial begin
        logic [RATE_BITS-1:0] alphas [5] = '{17'd6554, 17'd65536, 17'd0, 17'd131071, 17'd30000};
        logic [RATE_BITS-1:0] gammas [5] = '{17'd65536, 17'd0, 17'd65536, 17'd131071, 17'd50000};
        logic [RATE_BITS-1:0] epss [5] = '{17'd6554, 17'd0, 17'd65536, 17'd32768, 17'd20000};
        sent = 0; phases = 0; calm_sink = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_steps();
        drain();
        for (int p = 0; p < 5; p++) begin
            if (p > 0) set_rates(alphas[p], gammas[p], epss[p]);
            phases++;
            calm_sink = (p == 3);
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_step(rand_step(), (p == 3) ? 0 : gap_len());
            step_ch.valid <= 1'b0;
            drain();
        end
        calm_sink = 1'b0;
        $display("Covered %0d transfers over %0d rate settings, incl. rate clamping,", sent, phases);
        $display("saturating updates, empty legal masks and invalid actions.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* double_q_learning_update.f */
+incdir+design
design/dql_pkg.sv
design/dql_if.sv
design/dql_front.sv
design/dql_back.sv
design/double_q_learning_update.sv
tb/dql_tb_pkg.sv
tb/dql_checker.sv
tb/tb.sv
